### rtl/bfa_pkg.sv
// shared types and constants of the bitmap frame allocator
`default_nettype none

package bfa_pkg;

  localparam int unsigned FRAME_SHIFT = 12;
  localparam int unsigned ADDR_W      = 27;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned RANGE_FW    = 17;

  localparam logic [1:0] CMD_RELEASE  = 2'd0;
  localparam logic [1:0] CMD_RESERVE  = 2'd1;
  localparam logic [1:0] CMD_ALLOCATE = 2'd2;

  localparam logic [7:0] BYTE_FULL = 8'hFF;

  typedef enum logic [1:0] {
    MODE_CLEAR,
    MODE_SET,
    MODE_ALLOC
  } bfa_mode_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [14:0] range_start;
    logic [15:0] end_frame;
  } bfa_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] frame_address;
    logic              found;
  } bfa_out_t;

  typedef struct packed {
    logic [7:0] new_byte;
    logic       hit;
    logic [2:0] bit_idx;
  } bfa_byte_res_t;

endpackage

`default_nettype wire

### rtl/bfa_bitmap_ram.sv
// usage bitmap storage, one write port and one registered read port
`default_nettype none

module bfa_bitmap_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/bfa_byte_unit.sv
// shared byte update unit: range mask set or clear, lowest free bit search
`default_nettype none

module bfa_byte_unit
  import bfa_pkg::*;
#(
  parameter int unsigned FW = 17
) (
  input  wire logic [7:0]    byte_i,
  input  wire logic [FW-1:0] base_i,
  input  wire logic [FW-1:0] lo_i,
  input  wire logic [FW-1:0] hi_i,
  input  wire bfa_mode_e     mode_i,
  output bfa_byte_res_t      res_o
);

  logic [7:0]    mask;
  logic [FW-1:0] frame;
  logic [2:0]    idx;

  always_comb begin
    mask  = '0;
    frame = '0;
    for (int i = 0; i < 8; i++) begin
      frame   = {base_i[FW-1:3], 3'(i)};
      mask[i] = (frame >= lo_i) && (frame < hi_i);
    end
  end

  always_comb begin
    idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (!byte_i[i]) begin
        idx = 3'(i);
      end
    end
  end

  always_comb begin
    res_o.hit     = 1'b0;
    res_o.bit_idx = idx;
    unique case (mode_i)
      MODE_CLEAR: res_o.new_byte = byte_i & ~mask;
      MODE_SET:   res_o.new_byte = byte_i | mask;
      MODE_ALLOC: begin
        res_o.hit      = (byte_i != BYTE_FULL);
        res_o.new_byte = byte_i | (8'd1 << idx);
      end
      default:    res_o.new_byte = byte_i;
    endcase
  end

endmodule

`default_nettype wire

### rtl/bitmap_frame_allocator.sv
// bitmap page frame allocator top level with byte sequencer
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid_i in_ready_o in_data_i  | command word in
//  out     | out_valid_o out_ready_i out_data_o | result word out
//  cfg     | cfg_we_i cfg_data_i              | frame_count write
//
// after reset the bitmap is filled with ones, one byte per cycle, MAX_FRAMES/8
// bytes (4096 by default); in_ready_o stays low meanwhile.
// release and reserve read each bitmap byte touched, then modify it and write
// it back; allocate reads each byte scanned and writes back only the byte in
// which it finds a free bit; reads and writes share the bitmap address byte_q.
// one command is in flight at a time; a result waiting on out_ready_i holds
// the sequencer in its final state until the output register frees up.
`default_nettype none

module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 32768
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire bfa_in_t             in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output bfa_out_t                 out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [COUNT_W-1:0]  cfg_data_i
);

  localparam int unsigned MAP_BYTES = (MAX_FRAMES + 7) / 8;
  localparam int unsigned AW        = $clog2(MAP_BYTES);
  localparam int unsigned FW        = ($clog2(MAX_FRAMES) + 1 > RANGE_FW) ?
                                      $clog2(MAX_FRAMES) + 1 : RANGE_FW;
  localparam int unsigned CW        = FW - 3;
  localparam logic [FW-1:0] FRAMES_MAX = FW'(MAX_FRAMES);
  localparam logic [CW-1:0] LIMIT_MAX  = CW'(MAX_FRAMES / 8);
  localparam logic [CW-1:0] LAST_BYTE  = CW'(MAP_BYTES - 1);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_MODIFY,
    S_DONE
  } state_e;

  state_e               state_q;
  logic [CW-1:0]        byte_q;
  logic [CW-1:0]        limit_q;
  logic [FW-1:0]        lo_q;
  logic [FW-1:0]        hi_q;
  bfa_mode_e            mode_q;
  bfa_out_t             res_q;
  bfa_out_t             out_q;
  logic                 out_valid_q;
  logic [COUNT_W-1:0]   frame_count_q;

  logic [FW-1:0]        first_ext;
  logic [FW-1:0]        end_ext;
  logic [FW-1:0]        span_up;
  logic [FW-1:0]        hi_raw;
  logic [FW-1:0]        hi_clamp;
  logic                 range_empty;
  logic [CW-1:0]        fc_bytes;
  logic [CW-1:0]        limit_d;
  logic [CW:0]          byte_nxt;
  logic                 range_end;
  logic [14:0]          frame_idx;

  logic                 ram_we;
  logic [7:0]           ram_wdata;
  logic [7:0]           ram_rdata;
  bfa_byte_res_t        unit_res;

  // range bounds of a release or reserve word, and the byte limit of an allocate
  always_comb begin
    first_ext   = FW'(in_data_i.range_start);
    end_ext     = FW'(in_data_i.end_frame);
    span_up     = (end_ext - first_ext + FW'(7)) & ~FW'(7);
    hi_raw      = (in_data_i.command == CMD_RELEASE) ? end_ext : first_ext + span_up;
    hi_clamp    = (hi_raw > FRAMES_MAX) ? FRAMES_MAX : hi_raw;
    range_empty = (end_ext <= first_ext) || (first_ext >= hi_clamp);
    fc_bytes    = CW'(frame_count_q[COUNT_W-1:3]);
    limit_d     = (fc_bytes < LIMIT_MAX) ? fc_bytes : LIMIT_MAX;
  end

  assign byte_nxt  = {1'b0, byte_q} + (CW+1)'(1);
  assign range_end = {byte_nxt, 3'b000} >= {1'b0, hi_q};
  assign frame_idx = {byte_q[11:0], unit_res.bit_idx};

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = unit_res.new_byte;
    unique case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = BYTE_FULL;
      end
      S_MODIFY: ram_we = (mode_q != MODE_ALLOC) || unit_res.hit;
      default:  ram_we = 1'b0;
    endcase
  end

  bfa_bitmap_ram #(
    .DEPTH (MAP_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (byte_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (state_q == S_READ),
    .raddr_i (byte_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  bfa_byte_unit #(
    .FW (FW)
  ) u_unit (
    .byte_i (ram_rdata),
    .base_i ({byte_q, 3'b000}),
    .lo_i   (lo_q),
    .hi_i   (hi_q),
    .mode_i (mode_q),
    .res_o  (unit_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_INIT;
      byte_q        <= '0;
      limit_q       <= '0;
      lo_q          <= '0;
      hi_q          <= '0;
      res_q         <= '0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
      frame_count_q <= '0;
      mode_q        <= MODE_CLEAR;
    end else begin
      if (cfg_we_i) begin
        frame_count_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          if (byte_q == LAST_BYTE) begin
            state_q <= S_IDLE;
          end else begin
            byte_q <= byte_q + CW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            res_q   <= '0;
            lo_q    <= first_ext;
            hi_q    <= hi_clamp;
            limit_q <= limit_d;
            priority if (in_data_i.command == CMD_ALLOCATE) begin
              mode_q  <= MODE_ALLOC;
              byte_q  <= '0;
              state_q <= (limit_d == '0) ? S_DONE : S_READ;
            end else if (in_data_i.command == CMD_RELEASE ||
                         in_data_i.command == CMD_RESERVE) begin
              mode_q  <= (in_data_i.command == CMD_RELEASE) ? MODE_CLEAR : MODE_SET;
              byte_q  <= CW'(first_ext[FW-1:3]);
              state_q <= range_empty ? S_DONE : S_READ;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_READ: state_q <= S_MODIFY;
        S_MODIFY: begin
          byte_q <= byte_nxt[CW-1:0];
          if (mode_q == MODE_ALLOC) begin
            if (unit_res.hit) begin
              res_q.frame_address <= {frame_idx, {FRAME_SHIFT{1'b0}}};
              res_q.found         <= 1'b1;
              state_q             <= S_DONE;
            end else if (byte_nxt[CW-1:0] == limit_q) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_READ;
            end
          end else begin
            state_q <= range_end ? S_DONE : S_READ;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### verif/frame_alloc_checker.sv
// checker for the bitmap frame allocator: mirrors the usage bitmap and compares every result word
module frame_alloc_checker
  import bfa_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 32768
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  bfa_in_t            in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  bfa_out_t           out_data_i,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_data_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAP_BYTES = (MAX_FRAMES + 7) / 8;

  logic [7:0]         frame_map [MAP_BYTES];
  logic [COUNT_W-1:0] frame_count;
  bfa_out_t           reply_q [$];
  int unsigned        mismatches = 0;
  int unsigned        waiting = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  function automatic void mark_frame(input int unsigned frame, input logic used);
    if (frame < MAX_FRAMES) begin
      frame_map[frame / 8][frame % 8] = used;
    end
  endfunction

  function automatic bfa_out_t apply_command(input bfa_in_t w);
    bfa_out_t    r;
    int unsigned f;
    int unsigned g;
    int unsigned k;
    int unsigned b;
    int unsigned limit;
    int unsigned first;
    int unsigned last;
    logic [31:0] addr;
    r     = '0;
    first = w.range_start;
    last  = w.end_frame;
    case (w.command)
      CMD_RELEASE: begin
        for (f = first; f < last; f++) mark_frame(f, 1'b0);
      end
      CMD_RESERVE: begin
        // whole groups of eight, the last one may run past the end
        for (g = first; g < last; g += 8) begin
          for (k = 0; k < 8; k++) mark_frame(g + k, 1'b1);
        end
      end
      CMD_ALLOCATE: begin
        limit = frame_count / 8;
        if (limit > MAX_FRAMES / 8) limit = MAX_FRAMES / 8;
        for (b = 0; b < limit && !r.found; b++) begin
          if (frame_map[b] != BYTE_FULL) begin
            for (k = 0; k < 8 && !r.found; k++) begin
              if (!frame_map[b][k]) begin
                frame_map[b][k] = 1'b1;
                addr            = (b * 8 + k) << FRAME_SHIFT;
                r.frame_address = addr[ADDR_W-1:0];
                r.found         = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAP_BYTES; i++) frame_map[i] = BYTE_FULL;
      frame_count = '0;
      reply_q.delete();
      waiting = 0;
    end else begin : watch
      bfa_out_t want;
      if (out_valid_i && out_ready_i) begin
        if (reply_q.size() == 0) begin
          $error("unexpected result word: frame_address 0x%0h found %0d",
                 out_data_i.frame_address, out_data_i.found);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          if (out_data_i.frame_address !== want.frame_address) begin
            $error("frame_address: expected 0x%0h, actual 0x%0h",
                   want.frame_address, out_data_i.frame_address);
            mismatches++;
          end
          if (out_data_i.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_data_i.found);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) frame_count = cfg_data_i;
      if (in_valid_i && in_ready_i) reply_q.push_back(apply_command(in_data_i));
      waiting = reply_q.size();
    end
  end

endmodule

### verif/tb_bitmap_frame_allocator.sv
// top of the bitmap frame allocator testbench: clock, reset, stimulus and verdict
module tb_bitmap_frame_allocator;
  import bfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  CMD_SPARE      = 2'd3;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 100000;
  localparam int unsigned PHASE_ITEMS    = 58;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  bfa_in_t            in_data;
  logic               out_valid;
  logic               out_ready;
  bfa_out_t           out_data;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_data;
  int unsigned        fail_count;
  int unsigned        pending;

  logic        tx_quiet;
  logic        rx_quiet;
  logic        rx_hold_req;
  int unsigned idle_run;

  bitmap_frame_allocator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  frame_alloc_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bfa_in_t make_word(input int unsigned region);
    bfa_in_t     w;
    int unsigned r;
    int unsigned first;
    int unsigned last;
    int unsigned d;
    r = $urandom_range(0, 99);
    if (r < 30) w.command = CMD_RELEASE;
    else if (r < 50) w.command = CMD_RESERVE;
    else if (r < 95) w.command = CMD_ALLOCATE;
    else w.command = CMD_SPARE;
    if ($urandom_range(0, 9) < 8) first = $urandom_range(0, region);
    else first = $urandom_range(0, 32767);
    r = $urandom_range(0, 99);
    if (r < 80) begin
      last = first + $urandom_range(0, 24);
    end else if (r < 90) begin
      d    = $urandom_range(0, 16);
      last = (first > d) ? first - d : 0;
    end else if (r < 99) begin
      last = first + $urandom_range(0, 300);
    end else begin
      last = $urandom_range(0, 65535);
    end
    w.range_start = first[14:0];
    w.end_frame   = last[15:0];
    return w;
  endfunction

  task automatic send_word(input bfa_in_t w);
    int unsigned gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input int unsigned first,
                          input int unsigned last);
    bfa_in_t w;
    w.command     = cmd;
    w.range_start = first[14:0];
    w.end_frame   = last[15:0];
    send_word(w);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_frame_count(input logic [COUNT_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // receiver side: random stalls, quiet stretches and one long hold-off
  initial begin : receiver
    int unsigned stall;
    stall     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall != 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (!rx_quiet && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG_LIMIT) begin
      $display("** bitmap_frame_allocator: FAILED **");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin : stimulus
    logic [COUNT_W-1:0] fc_plan [10];
    int unsigned        region;
    int unsigned        items;
    fc_plan     = '{16'd64, 16'd13, 16'd512, 16'd8, 16'd1024,
                    16'd200, 16'd32768, 16'd96, 16'd0, 16'd256};
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    tx_quiet    = 1'b0;
    rx_quiet    = 1'b0;
    rx_hold_req = 1'b0;
    idle_run    = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // frame_count still zero: nothing can be handed out
    send_cmd(CMD_ALLOCATE, 0, 0);
    drain();

    set_frame_count(16'd64);
    send_cmd(CMD_ALLOCATE, 0, 0);
    send_cmd(CMD_RELEASE, 0, 16);
    send_cmd(CMD_ALLOCATE, 0, 0);
    send_cmd(CMD_ALLOCATE, 32767, 65535);
    send_cmd(CMD_RELEASE, 5, 3);
    send_cmd(CMD_RELEASE, 10, 10);
    send_cmd(CMD_RESERVE, 0, 1);
    send_cmd(CMD_ALLOCATE, 0, 0);
    send_cmd(CMD_RESERVE, 3, 12);
    send_cmd(CMD_RELEASE, 32760, 65535);
    send_cmd(CMD_RESERVE, 32767, 32768);
    send_cmd(CMD_SPARE, 32767, 65535);
    send_cmd(CMD_RESERVE, 0, 0);
    send_cmd(CMD_RELEASE, 0, 64);
    send_cmd(CMD_ALLOCATE, 0, 0);
    drain();

    // free frames only in the incomplete last byte
    set_frame_count(16'd60);
    send_cmd(CMD_RELEASE, 0, 64);
    send_cmd(CMD_RESERVE, 0, 56);
    send_cmd(CMD_ALLOCATE, 0, 0);
    drain();

    // count beyond capacity, only the top two frames free
    set_frame_count(16'hFFFF);
    send_cmd(CMD_RESERVE, 0, 32768);
    send_cmd(CMD_RELEASE, 32766, 32768);
    send_cmd(CMD_ALLOCATE, 0, 0);
    send_cmd(CMD_ALLOCATE, 0, 0);
    send_cmd(CMD_ALLOCATE, 0, 0);
    drain();

    for (int p = 0; p < 10; p++) begin
      set_frame_count(fc_plan[p]);
      region = fc_plan[p];
      if (region < 16) region = 64;
      if (region > 2048) region = 2048;
      items = (fc_plan[p] > 2048) ? 25 : PHASE_ITEMS;
      if (p == 2) begin
        @(posedge clk);
        rx_hold_req = 1'b1;
      end
      if (p == 3) begin
        @(posedge clk);
        rx_quiet = 1'b1;
      end
      for (int i = 0; i < items; i++) begin
        tx_quiet = (p == 3) || (p == 2 && i < 20);
        send_word(make_word(region));
      end
      tx_quiet = 1'b0;
      drain();
      rx_quiet = 1'b0;
    end

    repeat (50) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** bitmap_frame_allocator: PASSED **");
    end else begin
      $display("** bitmap_frame_allocator: FAILED **");
    end
    $finish;
  end

endmodule

### bitmap_frame_allocator.f
rtl/bfa_pkg.sv
rtl/bfa_bitmap_ram.sv
rtl/bfa_byte_unit.sv
rtl/bitmap_frame_allocator.sv
verif/frame_alloc_checker.sv
verif/tb_bitmap_frame_allocator.sv
